// ----- rtl/dtt_pkg.sv -----
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types, constants and status codes for the task table block.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int unsigned MAX_TASKS_DEF = 64;
  localparam int unsigned MAX_EDGES_DEF = 128;
  localparam int unsigned KEY_BITS_DEF  = 32;

  localparam int unsigned IN_KEY_W  = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned TASKS_W   = 7;
  localparam int unsigned EDGES_W   = 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_CYCLE   = 3'd4
  } status_t;

  localparam logic OP_ADD_TASK = 1'b0;
  localparam logic OP_ADD_EDGE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_ROWD,
    S_UPDATE,
    S_DONE
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input item, clear scan state
    logic scan;        // compare one key table entry
    logic read_rowd;   // issue read of closure row d
    logic upd;         // process one closure row
    logic commit_task; // append the key
    logic commit_edge; // append the edge
    logic set_status;  // latch status into the result
    status_t status;
  } dtt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic    is_edge;
    logic    scan_last;
    logic    upd_last;
    logic    first_found;
    logic    dep_found;
    logic    same_slot;
    logic    reach_dp;
    logic    tasks_full;
    logic    edges_full;
  } dtt_stat_t;

endpackage

// ----- rtl/dtt_if.sv -----
// ----------------------------------------------------------------------------
// dtt_in_if / dtt_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface dtt_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] first_key;
  logic [31:0] dependent_key;
  modport source (output valid, opcode, first_key, dependent_key, input ready);
  modport sink   (input valid, opcode, first_key, dependent_key, output ready);
endinterface

interface dtt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] tasks_held;
  logic [7:0] edges_held;
  modport source (output valid, status, tasks_held, edges_held, input ready);
  modport sink   (input valid, status, tasks_held, edges_held, output ready);
endinterface

// ----- rtl/dag_task_table_with_cycle_check_top.sv -----
// ----------------------------------------------------------------------------
// dag_task_table_with_cycle_check_top
// Task key table with dependency edges and incremental cycle check.
// Flow: an accepted item is scanned against the T tasks held when it is taken,
// then decided; an accepted edge adds a walk over the closure rows. The walk
// and the read of closure row d share the closure memory's one read port.
// Throughput: one item at a time; a new item waits until the last result is taken.
// Reset: synchronous active low; counters and row valid bits clear at once.
// ----------------------------------------------------------------------------
module dag_task_table_with_cycle_check_top
  import dtt_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF,
  parameter int unsigned MAX_EDGES = MAX_EDGES_DEF,
  parameter int unsigned KEY_BITS  = KEY_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  dtt_in_if.sink    in_ch,
  dtt_out_if.source out_ch
);

  dtt_cmd_t  cmd;
  dtt_stat_t stat;

  dtt_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .stat
  );

  dtt_datapath #(.MAX_TASKS(MAX_TASKS), .MAX_EDGES(MAX_EDGES), .KEY_BITS(KEY_BITS))
  u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_opcode       (in_ch.opcode),
    .in_first_key    (in_ch.first_key),
    .in_dependent_key(in_ch.dependent_key),
    .res_status      (out_ch.status),
    .res_tasks       (out_ch.tasks_held),
    .res_edges       (out_ch.edges_held)
  );

endmodule

// ----- rtl/dtt_datapath.sv -----
// ----------------------------------------------------------------------------
// dtt_datapath
// Key table, edge list, closure matrix memory and the counters.
// ----------------------------------------------------------------------------
module dtt_datapath
  import dtt_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF,
  parameter int unsigned MAX_EDGES = MAX_EDGES_DEF,
  parameter int unsigned KEY_BITS  = KEY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dtt_cmd_t             cmd,
  output dtt_stat_t            stat,
  input  logic                 in_opcode,
  input  logic [IN_KEY_W-1:0]  in_first_key,
  input  logic [IN_KEY_W-1:0]  in_dependent_key,
  output logic [STATUS_W-1:0]  res_status,
  output logic [TASKS_W-1:0]   res_tasks,
  output logic [EDGES_W-1:0]   res_edges
);

  localparam int unsigned TI_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned TC_W = $clog2(MAX_TASKS + 1);
  localparam int unsigned EI_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EC_W = $clog2(MAX_EDGES + 1);
  localparam int unsigned KW   = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;

  logic [KW-1:0]        key_mem [MAX_TASKS];
  logic [2*TI_W-1:0]    edge_mem [MAX_EDGES];
  logic [MAX_TASKS-1:0] reach_mem [MAX_TASKS];
  // One valid bit per closure row stands in for the all-zero reset.
  logic [MAX_TASKS-1:0] row_vld_r;

  logic [TC_W-1:0] task_total_r;
  logic [EC_W-1:0] edge_total_r;
  logic            op_r;
  logic [KW-1:0]   k1_r, k2_r;
  logic [TC_W-1:0] scan_r, scan_d_r;
  logic            f1_r, f2_r;
  logic [TI_W-1:0] p_r, d_r;
  logic [KW-1:0]   key_rd;
  logic [MAX_TASKS-1:0] rowd_r, rowd_rd, rowx_rd;
  logic [TC_W-1:0] upd_r;
  logic [TC_W-1:0] upd_d_r;
  logic            upd_v_r;
  logic [STATUS_W-1:0] st_r;

  // Key scan: registered read, compared in the next cycle; key and edge appends.
  always_ff @(posedge clk) begin
    key_rd <= key_mem[scan_r[TI_W-1:0]];
    if (cmd.commit_task) key_mem[task_total_r[TI_W-1:0]] <= k1_r;
    if (cmd.commit_edge) edge_mem[edge_total_r[EI_W-1:0]] <= {p_r, d_r};
  end

  logic scan_hit_ok;
  assign scan_hit_ok = upd_v_r && (scan_d_r < task_total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_total_r <= '0;
      edge_total_r <= '0;
      row_vld_r    <= '0;
      scan_r       <= '0;
      upd_v_r      <= 1'b0;
      f1_r         <= 1'b0;
      f2_r         <= 1'b0;
    end else begin
      upd_v_r <= cmd.scan;
      if (cmd.load) begin
        op_r   <= in_opcode;
        k1_r   <= in_first_key[KW-1:0];
        k2_r   <= in_dependent_key[KW-1:0];
        scan_r <= '0;
        f1_r   <= 1'b0;
        f2_r   <= 1'b0;
        upd_r  <= '0;
      end
      if (cmd.scan && scan_r < TC_W'(MAX_TASKS)) scan_r <= scan_r + 1'b1;
      scan_d_r <= scan_r;
      if (scan_hit_ok) begin
        if (!f1_r && key_rd == k1_r) begin f1_r <= 1'b1; p_r <= scan_d_r[TI_W-1:0]; end
        if (!f2_r && key_rd == k2_r) begin f2_r <= 1'b1; d_r <= scan_d_r[TI_W-1:0]; end
      end
      if (cmd.commit_task) task_total_r <= task_total_r + 1'b1;
      if (cmd.commit_edge) edge_total_r <= edge_total_r + 1'b1;
      if (cmd.upd) upd_r <= upd_r + 1'b1;
      upd_d_r <= upd_r;
      if (cmd.upd && upd_r != '0) begin
        // Row upd_d_r was read last cycle; merge when it reaches p.
        if (upd_d_r[TI_W-1:0] == p_r ||
            (row_vld_r[upd_d_r[TI_W-1:0]] && rowx_rd[p_r])) begin
          row_vld_r[upd_d_r[TI_W-1:0]] <= 1'b1;
        end
      end
      if (cmd.set_status) st_r <= cmd.status;
    end
  end

  // Closure memory: one read port, one write port.
  logic [MAX_TASKS-1:0] rowd_eff;
  assign rowd_eff = (row_vld_r[d_r] ? rowd_r : '0) | (MAX_TASKS'(1) << d_r);
  logic [MAX_TASKS-1:0] rowx_eff;
  assign rowx_eff = row_vld_r[upd_d_r[TI_W-1:0]] ? rowx_rd : '0;

  always_ff @(posedge clk) begin
    if (cmd.read_rowd) rowd_rd <= reach_mem[d_r];
    else rowx_rd <= reach_mem[upd_r[TI_W-1:0]];
    if (cmd.upd && upd_r != '0 &&
        (upd_d_r[TI_W-1:0] == p_r || rowx_eff[p_r]))
      reach_mem[upd_d_r[TI_W-1:0]] <= rowx_eff | rowd_eff;
  end
  // Row d is final once the decision is taken; it never changes during the walk.
  always_ff @(posedge clk) begin
    if (cmd.set_status) rowd_r <= rowd_rd;
  end

  logic [MAX_TASKS-1:0] rowdp_eff;
  assign rowdp_eff = row_vld_r[d_r] ? rowd_rd : '0;

  assign stat.is_edge     = op_r;
  // All reads are issued here; the compare of the last entry runs this cycle.
  assign stat.scan_last   = (scan_r >= task_total_r);
  assign stat.upd_last    = (upd_r > task_total_r) || (upd_r == TC_W'(MAX_TASKS));
  assign stat.first_found = f1_r;
  assign stat.dep_found   = f2_r;
  assign stat.same_slot   = (p_r == d_r);
  assign stat.reach_dp    = rowdp_eff[p_r];
  assign stat.tasks_full  = (task_total_r >= TC_W'(MAX_TASKS));
  assign stat.edges_full  = (edge_total_r >= EC_W'(MAX_EDGES));

  assign res_status = st_r;
  assign res_tasks  = TASKS_W'(task_total_r);
  assign res_edges  = EDGES_W'(edge_total_r);

endmodule

// ----- rtl/dtt_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtt_ctrl
// Sequencer: key scan, decision, closure update, result handshake.
// ----------------------------------------------------------------------------
module dtt_ctrl
  import dtt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output dtt_cmd_t  cmd,
  input  dtt_stat_t stat
);

  ctl_state_t state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       fail;
  status_t    st_dec;

  always_comb begin
    fail   = 1'b1;
    st_dec = ST_OK;
    if (!stat.is_edge) begin
      if (stat.first_found)     st_dec = ST_EXISTS;
      else if (stat.tasks_full) st_dec = ST_FULL;
      else fail = 1'b0;
    end else begin
      if (!stat.first_found || !stat.dep_found)  st_dec = ST_MISSING;
      else if (stat.same_slot || stat.reach_dp)  st_dec = ST_CYCLE;
      else if (stat.edges_full)                  st_dec = ST_FULL;
      else fail = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid && in_ready) state_nxt = S_SCAN;
      S_SCAN:   if (stat.scan_last) state_nxt = S_ROWD;
      S_ROWD:   state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = (fail || !stat.is_edge) ? S_DONE : S_UPDATE;
      S_UPDATE: if (stat.upd_last) state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.status = st_dec;
    case (state_r)
      S_IDLE:   cmd.load = in_valid && in_ready;
      S_SCAN:   begin cmd.scan = 1'b1; cmd.read_rowd = 1'b1; end
      S_ROWD:   cmd.read_rowd = 1'b1;
      S_DECIDE: begin
        cmd.set_status  = 1'b1;
        cmd.commit_task = !fail && !stat.is_edge;
        cmd.commit_edge = !fail && stat.is_edge;
      end
      S_UPDATE: cmd.upd = 1'b1;
      default:  cmd = '0;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_valid && out_ready) ov_nxt = 1'b0;
    if (state_r == S_DONE) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // The result shows the live counters, so a new item is taken only once the
  // previous result has been accepted.
  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;

endmodule

// ----- rtl/dtt_checker.sv -----
// ----------------------------------------------------------------------------
// dtt_port_props
// Port-level checks on the task table block.
// ----------------------------------------------------------------------------
module dtt_port_props
  import dtt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");

  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("item accepted while result pending");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 3'd4)
    else $error("bad status");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("block idle right after accepting an item");

endmodule

bind dag_task_table_with_cycle_check_top dtt_port_props u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status)
);
